/* design/pagerank_power_iteration_top_assert.svh */
// Assertion macros used by the checker file of the rank engine.
// No dependencies; the including module must provide clk and rst_n.
`ifndef PAGERANK_POWER_ITERATION_TOP_ASSERT_SVH
`define PAGERANK_POWER_ITERATION_TOP_ASSERT_SVH

// same-cycle implication
`define PRI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/pri_pkg.sv */
// Shared types and constants of the rank engine.
// No dependencies.
package pri_pkg;

  // input word: one link-matrix row
  typedef struct packed {
    logic [31:0] row_links;
    logic        last_row;
  } pri_in_t;

  // output word: one page rank
  typedef struct packed {
    logic [4:0]  page_index;
    logic [30:0] rank_value;
    logic        last_rank;
  } pri_out_t;

  // lane controls from the sequencer
  typedef struct packed {
    logic clr;
    logic add;
    logic mul;
    logic upd;
    logic init;
    logic copy;
  } pri_lane_ctl_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_TELE_GO,
    ST_TELE_WAIT,
    ST_INIT_GO,
    ST_INIT_WAIT,
    ST_ITER,
    ST_FETCH,
    ST_SHARE_GO,
    ST_SHARE_WAIT,
    ST_MUL,
    ST_UPD,
    ST_MERGE,
    ST_DECIDE,
    ST_EMIT
  } pri_state_t;

  // register indexes
  localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_DAMPING     = 2'd1;
  localparam logic [1:0] REG_MAX_ITER    = 2'd2;
  localparam logic [1:0] REG_CONV_LIMIT  = 2'd3;

  localparam logic [16:0] DAMP_ONE = 17'd65536;

endpackage

/* design/pri_div.sv */
// Restoring divider, one quotient bit per cycle, 6-bit divisor.
// Depends on nothing outside this file.
module pri_div #(
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [5:0]    divisor,
  output logic          done,
  output logic [DW-1:0] quot
);
  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   q_r;
  logic [5:0]      rem_r;
  logic [5:0]      dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [6:0]      trial;
  logic            ge;

  // trial subtract of the shifted remainder
  assign trial = {rem_r, q_r[DW-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? 6'(trial - {1'b0, dvs_r}) : 6'(trial);
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

/* design/pri_lane.sv */
// One column lane: accumulates incoming rank shares, applies damping and
// teleport, holds the current and next rank. Uses pri_pkg.
module pri_lane #(
  parameter int RW = 31,
  parameter int SW = 36
) (
  input  logic                  clk,
  input  pri_pkg::pri_lane_ctl_t ctl,
  input  logic [RW-1:0]         share,
  input  logic                  add_en,
  input  logic [RW-1:0]         init_val,
  input  logic [16:0]           dval,
  input  logic [RW-1:0]         tele,
  output logic [RW-1:0]         rank,
  output logic [RW-1:0]         diff
);
  import pri_pkg::*;

  localparam int LO = (SW + 1) / 2;
  localparam int HI = SW - LO;
  localparam int PW = 17 + SW;

  logic [SW-1:0]   sum_r;
  logic [16+LO:0]  plo_r;
  logic [16+HI:0]  phi_r;
  logic [RW-1:0]   nxt_r;
  logic [RW-1:0]   rank_r;
  logic [PW-1:0]   full;
  logic [PW:0]     tsum;
  logic [PW:0]     one_w;
  logic [RW-1:0]   v;

  // recombine the split product, scale by 2^-16, add teleport, saturate
  always_comb begin
    full  = (PW'(phi_r) << LO) + PW'(plo_r);
    tsum  = (PW+1)'(tele) + (PW+1)'(full >> 16);
    one_w = (PW+1)'(1) << (RW - 1);
    v     = (tsum > one_w) ? RW'(one_w) : RW'(tsum);
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      sum_r <= '0;
    end else if (ctl.add && add_en) begin
      sum_r <= sum_r + SW'(share);
    end
    // damping multiply in two halves
    if (ctl.mul) begin
      plo_r <= dval * sum_r[LO-1:0];
      phi_r <= dval * sum_r[SW-1:LO];
    end
    if (ctl.upd) nxt_r <= v;
    if (ctl.init) begin
      rank_r <= init_val;
    end else if (ctl.copy) begin
      rank_r <= nxt_r;
    end
  end

  assign rank = rank_r;
  assign diff = (nxt_r >= rank_r) ? (nxt_r - rank_r) : (rank_r - nxt_r);
endmodule

/* design/pagerank_power_iteration_top.sv */
// PageRank engine by power iteration. Rows of the link matrix load one word
// per cycle; the word with last_row set starts the computation and the input
// stalls until the final rank word sits in the output register; rank words
// leave one per cycle while out_stall is low, page 0 first.
// Compute time is set by the shared bit-serial divider, which forms the
// teleport term and the initial rank once, then one share per row in every
// iteration, for up to max_iterations iterations; the column lanes add shares
// and apply damping in parallel.
module pagerank_power_iteration_top #(
  parameter int MAX_NODES      = 32,
  parameter int RANK_FRAC_BITS = 30
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pri_pkg::pri_in_t  in_word,
  output logic            out_valid,
  input  logic            out_stall,
  output pri_pkg::pri_out_t out_word,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import pri_pkg::*;

  localparam int NODE_CAP = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int IW       = $clog2(NODE_CAP);
  localparam int CW       = $clog2(NODE_CAP + 1);
  localparam int RW       = RANK_FRAC_BITS + 1;
  localparam int SW       = RW + 5;

  // configuration registers
  logic [5:0]  node_count_r;
  logic [16:0] damping_r;
  logic [7:0]  max_iter_r;
  logic [30:0] limit_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 6'd4;
      damping_r    <= 17'd55706;
      max_iter_r   <= 8'd100;
      limit_r      <= 31'd11;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NODE_COUNT: node_count_r <= pwdata[5:0];
        REG_DAMPING:    damping_r    <= pwdata[16:0];
        REG_MAX_ITER:   max_iter_r   <= pwdata[7:0];
        REG_CONV_LIMIT: limit_r      <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NODE_COUNT: prdata = 32'(node_count_r);
      REG_DAMPING:    prdata = 32'(damping_r);
      REG_MAX_ITER:   prdata = 32'(max_iter_r);
      REG_CONV_LIMIT: prdata = 32'(limit_r);
      default:        prdata = '0;
    endcase
  end

  // effective page count, damping and column mask
  logic [5:0]    n;
  logic [16:0]   dclip;
  logic [31:0]   col_mask;
  logic [RW-1:0] tele_num;
  logic [RW-1:0] one_val;

  always_comb begin
    if (node_count_r == 6'd0) n = 6'd1;
    else if (node_count_r > 6'(NODE_CAP)) n = 6'(NODE_CAP);
    else n = node_count_r;
    dclip = (damping_r > DAMP_ONE) ? DAMP_ONE : damping_r;
    for (int k = 0; k < 32; k++) col_mask[k] = (k < int'(n));
    tele_num = RW'(DAMP_ONE - dclip) << (RANK_FRAC_BITS - 16);
    one_val  = RW'(1) << RANK_FRAC_BITS;
  end

  // state and counters
  pri_state_t    state_r, state_nxt;
  logic [CW-1:0] row_cnt_r;
  logic [IW-1:0] idx_r;
  logic [7:0]    iter_r;
  logic [SW-1:0] change_r;
  logic [RW-1:0] tele_r;
  logic [31:0]   row_r;
  logic          deg0_r;
  logic [31:0]   link_r [NODE_CAP];
  logic          idx_last;
  logic          in_acc;
  logic          out_take;
  logic          out_valid_r;
  pri_out_t      out_word_r;

  pri_lane_ctl_t lctl;
  logic          div_start;
  logic [RW-1:0] div_dvd;
  logic [5:0]    div_dvs;
  logic          div_done;
  logic [RW-1:0] div_q;
  logic [5:0]    deg;
  logic [RW-1:0] rank_w [NODE_CAP];
  logic [RW-1:0] diff_w [NODE_CAP];
  logic [63:0]   rank_ext;

  assign idx_last = (6'(idx_r) == n - 6'd1);
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = !out_valid_r || !out_stall;
  assign deg      = 6'($countones(row_r));
  assign rank_ext = 64'(rank_w[idx_r]);

  // shared divider: teleport, initial rank and per-row share
  pri_div #(.DW(RW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  // column lanes
  for (genvar k = 0; k < NODE_CAP; k++) begin : g_lane
    pri_lane #(.RW(RW), .SW(SW)) u_lane (
      .clk      (clk),
      .ctl      (lctl),
      .share    (div_q),
      .add_en   (deg0_r || row_r[k]),
      .init_val (div_q),
      .dval     (dclip),
      .tele     (tele_r),
      .rank     (rank_w[k]),
      .diff     (diff_w[k])
    );
  end

  // sequencer: next state, lane controls, divider start
  always_comb begin
    state_nxt = state_r;
    lctl      = '0;
    div_start = 1'b0;
    div_dvd   = tele_num;
    div_dvs   = n;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_word.last_row) state_nxt = ST_TELE_GO;
      end
      ST_TELE_GO: begin
        div_start = 1'b1;
        state_nxt = ST_TELE_WAIT;
      end
      ST_TELE_WAIT: begin
        if (div_done) state_nxt = ST_INIT_GO;
      end
      ST_INIT_GO: begin
        div_start = 1'b1;
        div_dvd   = one_val;
        state_nxt = ST_INIT_WAIT;
      end
      ST_INIT_WAIT: begin
        if (div_done) begin
          lctl.init = 1'b1;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (iter_r < max_iter_r) begin
          lctl.clr  = 1'b1;
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_FETCH: state_nxt = ST_SHARE_GO;
      ST_SHARE_GO: begin
        div_start = 1'b1;
        div_dvd   = rank_w[idx_r];
        div_dvs   = (deg == 6'd0) ? n : deg;
        state_nxt = ST_SHARE_WAIT;
      end
      ST_SHARE_WAIT: begin
        if (div_done) begin
          lctl.add  = 1'b1;
          state_nxt = idx_last ? ST_MUL : ST_FETCH;
        end
      end
      ST_MUL: begin
        lctl.mul  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        lctl.upd  = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (idx_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (64'(change_r) < 64'(limit_r)) begin
          state_nxt = ST_EMIT;
        end else begin
          lctl.copy = 1'b1;
          state_nxt = ST_ITER;
        end
      end
      ST_EMIT: begin
        if (out_take && idx_last) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end

  // control counters and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      idx_r       <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_LOAD: begin
          if (in_acc && row_cnt_r < CW'(NODE_CAP)) row_cnt_r <= row_cnt_r + CW'(1);
        end
        ST_INIT_WAIT: iter_r <= '0;
        ST_ITER: idx_r <= '0;
        ST_SHARE_WAIT: begin
          if (div_done) idx_r <= idx_last ? '0 : idx_r + IW'(1);
        end
        ST_MERGE: idx_r <= idx_last ? '0 : idx_r + IW'(1);
        ST_DECIDE: begin
          idx_r <= '0;
          if (64'(change_r) >= 64'(limit_r)) iter_r <= iter_r + 8'd1;
        end
        ST_EMIT: begin
          if (out_take) begin
            out_valid_r <= 1'b1;
            idx_r       <= idx_last ? '0 : idx_r + IW'(1);
            if (idx_last) row_cnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && in_acc && row_cnt_r < CW'(NODE_CAP)) begin
      link_r[row_cnt_r[IW-1:0]] <= in_word.row_links;
    end
    if (state_r == ST_TELE_WAIT && div_done) tele_r <= div_q;
    if (state_r == ST_FETCH) row_r <= link_r[idx_r] & col_mask;
    if (state_r == ST_SHARE_GO) deg0_r <= (deg == 6'd0);
    if (state_r == ST_UPD) change_r <= '0;
    if (state_r == ST_MERGE) change_r <= change_r + SW'(diff_w[idx_r]);
    if (state_r == ST_EMIT && out_take) begin
      out_word_r.page_index <= 5'(idx_r);
      out_word_r.rank_value <= rank_ext[30:0];
      out_word_r.last_rank  <= idx_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule

/* design/pri_checker.sv */
// Port-level checks on the rank engine, bound to the top level.
// Depends on pri_pkg and the assertion macro header.
`include "pagerank_power_iteration_top_assert.svh"

module pri_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input pri_pkg::pri_in_t  in_word,
  input logic              out_valid,
  input logic              out_stall,
  input pri_pkg::pri_out_t out_word,
  input logic              pready
);
  import pri_pkg::*;

  // held result word stays put
  `PRI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  // final row starts the computation, input closes
  `PRI_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && in_word.last_row, in_stall)
  // input stays closed until the final rank word is in the output register
  `PRI_ASSERT_NEXT(a_emit_stalls, out_valid && !out_stall && !out_word.last_rank, in_stall || out_word.last_rank)
  // register port never waits
  `PRI_ASSERT_NOW(a_pready, 1'b1, pready)
endmodule

bind pagerank_power_iteration_top pri_checker u_pri_checker (.*);
